// ----- src/duplicate_suppression_cache_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Duplicate suppression cache assertion macros
// Shared concurrent assertion forms for the duplicate suppression cache.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_SUPPRESSION_CACHE_UNIT_DEFINES_SVH
`define DUPLICATE_SUPPRESSION_CACHE_UNIT_DEFINES_SVH

// Implication or plain property checked at every rising edge outside reset.
`define DSC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("duplicate suppression cache assertion failed");

// Condition that must hold in the cycle after a trigger.
`define DSC_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("duplicate suppression cache assertion failed");

`endif

// ----- src/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Duplicate suppression cache package
// Word types, kind codes and sequencer states for the duplicate suppression cache.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int EXPIRY_W = 16;
    localparam int COUNT_W  = 7;

    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd10;

    typedef enum logic [1:0] {
        KIND_NET   = 2'd0,
        KIND_LOCAL = 2'd1,
        KIND_GC    = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   msg_id;
        logic [TIME_W-1:0] now_seconds;
    } in_word_t;

    typedef struct packed {
        logic               deliver_local;
        logic               forward;
        logic [COUNT_W-1:0] removed_count;
        logic               evicted_oldest;
        logic [COUNT_W-1:0] entries_held;
    } out_word_t;

endpackage

// ----- src/duplicate_suppression_cache_unit.sv -----
// ----------------------------------------------------------------------------
// Duplicate suppression cache unit
// Seen-message ring table with time-based expiry for flooding dissemination.
// ----------------------------------------------------------------------------
// Usage: one input word on s_valid/s_ready/s_data gives exactly one result word
// on m_valid/m_ready/m_data. The expiry register is written on cfg_valid/
// cfg_ready/cfg_data; the user must write it only while the unit is idle, as
// the unit itself does not enforce this; cfg_ready is always high.
// A network word scans the live entries through a single comparator, one
// entry a cycle, from the oldest slot, with one read port on the id memory.
// A new id scans every held entry before its insert; a duplicate stops the scan
// at its match. A garbage-collect word makes one expiry compare a cycle on the
// time memory read port. Kind 3 changes nothing. The unit takes one word at a
// time; s_ready is high only when idle.
// A finished result sits in the output register while the next word is taken;
// if the receiver stalls with a result still waiting, the following result
// holds the unit until the output register frees up.
// Reset empties the table at once (held count and ring pointers cleared) and
// sets the expiry to 10 seconds; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module duplicate_suppression_cache_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dsc_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dsc_pkg::out_word_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsc_pkg::EXPIRY_W-1:0]   cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_DEPTH);

    logic [dsc_pkg::ID_W-1:0]   id_mem   [TABLE_DEPTH];
    logic [dsc_pkg::TIME_W-1:0] time_mem [TABLE_DEPTH];

    dsc_pkg::state_t state_reg, state_next;

    logic [1:0]                     kind_reg;
    logic [dsc_pkg::ID_W-1:0]       id_reg;
    logic [dsc_pkg::TIME_W-1:0]     now_reg;
    logic [dsc_pkg::EXPIRY_W-1:0]   expiry_reg;
    logic [AW-1:0]                  oldest_reg;
    logic [AW-1:0]                  tail_reg;
    logic [CW-1:0]                  held_reg;
    logic [AW-1:0]                  scan_slot_reg;
    logic [CW-1:0]                  remain_reg;
    logic                           pend_reg;
    logic [CW-1:0]                  removed_reg;
    logic                           deliver_reg;
    logic                           evicted_reg;
    logic [dsc_pkg::ID_W-1:0]       id_rd_reg;
    logic [dsc_pkg::TIME_W-1:0]     time_rd_reg;
    logic                           m_valid_reg;
    dsc_pkg::out_word_t             m_data_reg;

    logic                           accept;
    logic                           issue;
    logic                           is_gc;
    logic                           id_hit;
    logic                           expired;
    logic                           scan_stop;
    logic                           scan_end;
    logic                           out_free;
    logic [dsc_pkg::TIME_W:0]       limit;
    dsc_pkg::out_word_t             out_next;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.kind)
                        dsc_pkg::KIND_NET:   state_next = dsc_pkg::ST_SCAN;
                        dsc_pkg::KIND_LOCAL: state_next = dsc_pkg::ST_INSERT;
                        dsc_pkg::KIND_GC:    state_next = dsc_pkg::ST_SCAN;
                        default:             state_next = dsc_pkg::ST_DONE;
                    endcase
                end
            end
            dsc_pkg::ST_SCAN: begin
                priority if (scan_stop) begin
                    state_next = dsc_pkg::ST_DONE;
                end else if (scan_end) begin
                    state_next = is_gc ? dsc_pkg::ST_DONE : dsc_pkg::ST_INSERT;
                end else begin
                    state_next = dsc_pkg::ST_SCAN;
                end
            end
            dsc_pkg::ST_INSERT: begin
                state_next = dsc_pkg::ST_DONE;
            end
            dsc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = dsc_pkg::ST_IDLE;
                end
            end
            default: state_next = dsc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs and the shared compare unit.
    always_comb begin
        s_ready   = (state_reg == dsc_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        accept    = s_valid && s_ready;
        out_free  = !m_valid_reg || m_ready;
        is_gc     = (kind_reg == dsc_pkg::KIND_GC);
        issue     = (state_reg == dsc_pkg::ST_SCAN) && (remain_reg != '0);
        limit     = {1'b0, time_rd_reg} + (dsc_pkg::TIME_W + 1)'(expiry_reg);
        id_hit    = pend_reg && (id_rd_reg == id_reg);
        expired   = pend_reg && (limit < {1'b0, now_reg});
        scan_stop = is_gc ? (pend_reg && !expired) : id_hit;
        scan_end  = !issue && !pend_reg;

        out_next.deliver_local  = deliver_reg;
        out_next.forward        = deliver_reg;
        out_next.removed_count  = dsc_pkg::COUNT_W'(removed_reg);
        out_next.evicted_oldest = evicted_reg;
        out_next.entries_held   = dsc_pkg::COUNT_W'(held_reg);
    end

    always_ff @(posedge aclk) begin
        id_rd_reg   <= id_mem[scan_slot_reg];
        time_rd_reg <= time_mem[scan_slot_reg];
        if (state_reg == dsc_pkg::ST_INSERT) begin
            id_mem[tail_reg]   <= id_reg;
            time_mem[tail_reg] <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_data.kind;
            id_reg   <= s_data.msg_id;
            now_reg  <= s_data.now_seconds;
        end
        if (state_reg == dsc_pkg::ST_DONE && out_free) begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dsc_pkg::ST_IDLE;
            expiry_reg    <= dsc_pkg::EXPIRY_RESET;
            oldest_reg    <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            scan_slot_reg <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            removed_reg   <= '0;
            deliver_reg   <= 1'b0;
            evicted_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                expiry_reg <= cfg_data;
            end
            if (accept) begin
                scan_slot_reg <= oldest_reg;
                remain_reg    <= held_reg;
                pend_reg      <= 1'b0;
                removed_reg   <= '0;
                deliver_reg   <= 1'b0;
                evicted_reg   <= 1'b0;
            end
            if (state_reg == dsc_pkg::ST_SCAN) begin
                pend_reg <= issue;
                if (issue) begin
                    scan_slot_reg <= (scan_slot_reg == LAST_SLOT) ? '0 : scan_slot_reg + 1'b1;
                    remain_reg    <= remain_reg - 1'b1;
                end
                if (is_gc && expired) begin
                    oldest_reg  <= (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                    held_reg    <= held_reg - 1'b1;
                    removed_reg <= removed_reg + 1'b1;
                end
            end
            if (state_reg == dsc_pkg::ST_INSERT) begin
                deliver_reg <= 1'b1;
                tail_reg    <= (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                if (held_reg == FULL_CNT) begin
                    oldest_reg  <= (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
                    evicted_reg <= 1'b1;
                end else begin
                    held_reg <= held_reg + 1'b1;
                end
            end
            if (state_reg == dsc_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/dsc_checker.sv -----
// ----------------------------------------------------------------------------
// Duplicate suppression cache checker
// Port-level assertions for the duplicate suppression cache, bound to the top.
// ----------------------------------------------------------------------------
`include "duplicate_suppression_cache_unit_defines.svh"

module dsc_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input dsc_pkg::in_word_t            s_data,
    input logic                         m_valid,
    input logic                         m_ready,
    input dsc_pkg::out_word_t           m_data,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [dsc_pkg::EXPIRY_W-1:0] cfg_data
);

    // The unit works on one word at a time, so it closes right after an accept.
    `DSC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A waiting result word holds still while the receiver stalls.
    `DSC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Local delivery and forwarding always go together.
    `DSC_ASSERT(a_deliver_forward, aclk, aresetn, !m_valid || (m_data.deliver_local == m_data.forward))

    // Eviction only happens on an insert, and collection never inserts.
    `DSC_ASSERT(a_evict_with_insert, aclk, aresetn, !m_valid || !m_data.evicted_oldest || (m_data.deliver_local && m_data.removed_count == '0))

    // The table never reports more entries than it has slots.
    `DSC_ASSERT(a_held_bound, aclk, aresetn, !m_valid || (TABLE_DEPTH > 127) || (int'(m_data.entries_held) <= TABLE_DEPTH))

endmodule

bind duplicate_suppression_cache_unit dsc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dsc_checker (.*);
